// ----- design/c8alu_pkg.sv -----
package c8alu_pkg;

  localparam int unsigned ModeW = 5;
  localparam int unsigned SelW  = 3;

  // Operation codes
  localparam logic [ModeW-1:0] MODE_ORA  = 5'd0;
  localparam logic [ModeW-1:0] MODE_AND  = 5'd1;
  localparam logic [ModeW-1:0] MODE_EOR  = 5'd2;
  localparam logic [ModeW-1:0] MODE_ADC  = 5'd3;
  localparam logic [ModeW-1:0] MODE_SBC  = 5'd4;
  localparam logic [ModeW-1:0] MODE_CMP  = 5'd5;
  localparam logic [ModeW-1:0] MODE_CPX  = 5'd6;
  localparam logic [ModeW-1:0] MODE_CPY  = 5'd7;
  localparam logic [ModeW-1:0] MODE_LDA  = 5'd8;
  localparam logic [ModeW-1:0] MODE_LDX  = 5'd9;
  localparam logic [ModeW-1:0] MODE_LDY  = 5'd10;
  localparam logic [ModeW-1:0] MODE_BIT  = 5'd11;
  localparam logic [ModeW-1:0] MODE_ASL  = 5'd12;
  localparam logic [ModeW-1:0] MODE_ROL  = 5'd13;
  localparam logic [ModeW-1:0] MODE_LSR  = 5'd14;
  localparam logic [ModeW-1:0] MODE_ROR  = 5'd15;
  localparam logic [ModeW-1:0] MODE_INC  = 5'd16;
  localparam logic [ModeW-1:0] MODE_DEC  = 5'd17;
  localparam logic [ModeW-1:0] MODE_STA  = 5'd18;
  localparam logic [ModeW-1:0] MODE_STX  = 5'd19;
  localparam logic [ModeW-1:0] MODE_STY  = 5'd20;
  localparam logic [ModeW-1:0] MODE_TFR  = 5'd21;
  localparam logic [ModeW-1:0] MODE_FLAG = 5'd22;

  // Register select codes
  localparam logic [SelW-1:0] SEL_MEM = 3'd0;
  localparam logic [SelW-1:0] SEL_A   = 3'd1;
  localparam logic [SelW-1:0] SEL_X   = 3'd2;
  localparam logic [SelW-1:0] SEL_Y   = 3'd3;
  localparam logic [SelW-1:0] SEL_SP  = 3'd4;

  // Status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] KEEP_NZ   = 8'h7D;
  localparam logic [7:0] KEEP_NZC  = 8'h7C;
  localparam logic [7:0] KEEP_NVZC = 8'h3C;
  localparam logic [7:0] KEEP_NVZ  = 8'h3D;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [7:0]       operand;
    logic [SelW-1:0]  target_reg;
    logic [SelW-1:0]  source_reg;
    logic [2:0]       flag_index;
  } op_t;

  function automatic logic [7:0] nz_bits(logic [7:0] v);
    logic [7:0] b;
    b = 8'h00;
    b[FLAG_N] = v[7];
    b[FLAG_Z] = (v == 8'h00);
    return b;
  endfunction

endpackage

// ----- design/c8alu_exec.sv -----
module c8alu_exec (
  input  c8alu_pkg::op_t   op,
  input  c8alu_pkg::regs_t cur,
  output c8alu_pkg::regs_t nxt,
  output logic [7:0]       result_byte,
  output logic             writes_memory
);

  logic [7:0] add_opnd;
  logic [8:0] add_sum;
  logic       add_v;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_sum;
  logic [7:0] tgt_val;
  logic       tgt_ok;
  logic [7:0] src_val;
  logic       src_ok;
  logic [7:0] rmw_val;
  logic       rmw_cout;
  logic [7:0] p_tmp;

  always_comb begin
    add_opnd = (op.mode == c8alu_pkg::MODE_SBC) ? ~op.operand : op.operand;
    add_sum  = {1'b0, cur.a} + {1'b0, add_opnd} + {8'h00, cur.p[c8alu_pkg::FLAG_C]};
    add_v    = (cur.a[7] ^ add_sum[7]) & (add_opnd[7] ^ add_sum[7]);

    unique case (op.mode)
      c8alu_pkg::MODE_CPX: cmp_reg = cur.x;
      c8alu_pkg::MODE_CPY: cmp_reg = cur.y;
      default:             cmp_reg = cur.a;
    endcase
    cmp_sum = {1'b0, cmp_reg} + {1'b0, ~op.operand} + 9'd1;

    tgt_ok = 1'b1;
    unique case (op.target_reg)
      c8alu_pkg::SEL_MEM: tgt_val = op.operand;
      c8alu_pkg::SEL_A:   tgt_val = cur.a;
      c8alu_pkg::SEL_X:   tgt_val = cur.x;
      c8alu_pkg::SEL_Y:   tgt_val = cur.y;
      c8alu_pkg::SEL_SP:  tgt_val = cur.sp;
      default: begin
        tgt_val = 8'h00;
        tgt_ok  = 1'b0;
      end
    endcase

    src_ok = 1'b1;
    unique case (op.source_reg)
      c8alu_pkg::SEL_A:  src_val = cur.a;
      c8alu_pkg::SEL_X:  src_val = cur.x;
      c8alu_pkg::SEL_Y:  src_val = cur.y;
      c8alu_pkg::SEL_SP: src_val = cur.sp;
      default: begin
        src_val = 8'h00;
        src_ok  = 1'b0;
      end
    endcase

    rmw_cout = 1'b0;
    unique case (op.mode)
      c8alu_pkg::MODE_ASL: begin
        rmw_val  = {tgt_val[6:0], 1'b0};
        rmw_cout = tgt_val[7];
      end
      c8alu_pkg::MODE_ROL: begin
        rmw_val  = {tgt_val[6:0], cur.p[c8alu_pkg::FLAG_C]};
        rmw_cout = tgt_val[7];
      end
      c8alu_pkg::MODE_LSR: begin
        rmw_val  = {1'b0, tgt_val[7:1]};
        rmw_cout = tgt_val[0];
      end
      c8alu_pkg::MODE_ROR: begin
        rmw_val  = {cur.p[c8alu_pkg::FLAG_C], tgt_val[7:1]};
        rmw_cout = tgt_val[0];
      end
      c8alu_pkg::MODE_INC: rmw_val = tgt_val + 8'd1;
      default:             rmw_val = tgt_val - 8'd1;
    endcase
  end

  always_comb begin
    nxt           = cur;
    result_byte   = 8'h00;
    writes_memory = 1'b0;
    p_tmp         = 8'h00;

    unique case (op.mode)
      c8alu_pkg::MODE_ORA, c8alu_pkg::MODE_AND, c8alu_pkg::MODE_EOR: begin
        if (op.mode == c8alu_pkg::MODE_ORA) begin
          nxt.a = cur.a | op.operand;
        end else if (op.mode == c8alu_pkg::MODE_AND) begin
          nxt.a = cur.a & op.operand;
        end else begin
          nxt.a = cur.a ^ op.operand;
        end
        nxt.p       = (cur.p & c8alu_pkg::KEEP_NZ) | c8alu_pkg::nz_bits(nxt.a);
        result_byte = nxt.a;
      end
      c8alu_pkg::MODE_ADC, c8alu_pkg::MODE_SBC: begin
        nxt.a = add_sum[7:0];
        p_tmp = (cur.p & c8alu_pkg::KEEP_NVZC) | c8alu_pkg::nz_bits(add_sum[7:0]);
        p_tmp[c8alu_pkg::FLAG_V] = add_v;
        p_tmp[c8alu_pkg::FLAG_C] = add_sum[8];
        nxt.p       = p_tmp;
        result_byte = add_sum[7:0];
      end
      c8alu_pkg::MODE_CMP, c8alu_pkg::MODE_CPX, c8alu_pkg::MODE_CPY: begin
        // V is kept
        p_tmp = (cur.p & c8alu_pkg::KEEP_NZC) | c8alu_pkg::nz_bits(cmp_sum[7:0]);
        p_tmp[c8alu_pkg::FLAG_C] = cmp_sum[8];
        nxt.p = p_tmp;
      end
      c8alu_pkg::MODE_LDA, c8alu_pkg::MODE_LDX, c8alu_pkg::MODE_LDY: begin
        if (op.mode == c8alu_pkg::MODE_LDA) begin
          nxt.a = op.operand;
        end else if (op.mode == c8alu_pkg::MODE_LDX) begin
          nxt.x = op.operand;
        end else begin
          nxt.y = op.operand;
        end
        nxt.p       = (cur.p & c8alu_pkg::KEEP_NZ) | c8alu_pkg::nz_bits(op.operand);
        result_byte = op.operand;
      end
      c8alu_pkg::MODE_BIT: begin
        p_tmp = (cur.p & c8alu_pkg::KEEP_NVZ) | (op.operand & 8'hC0);
        p_tmp[c8alu_pkg::FLAG_Z] = ((op.operand & cur.a) == 8'h00);
        nxt.p = p_tmp;
      end
      c8alu_pkg::MODE_ASL, c8alu_pkg::MODE_ROL, c8alu_pkg::MODE_LSR,
      c8alu_pkg::MODE_ROR, c8alu_pkg::MODE_INC, c8alu_pkg::MODE_DEC: begin
        if (tgt_ok) begin
          if (op.mode == c8alu_pkg::MODE_INC || op.mode == c8alu_pkg::MODE_DEC) begin
            nxt.p = (cur.p & c8alu_pkg::KEEP_NZ) | c8alu_pkg::nz_bits(rmw_val);
          end else begin
            p_tmp = (cur.p & c8alu_pkg::KEEP_NZC) | c8alu_pkg::nz_bits(rmw_val);
            p_tmp[c8alu_pkg::FLAG_C] = rmw_cout;
            nxt.p = p_tmp;
          end
          unique case (op.target_reg)
            c8alu_pkg::SEL_A:  nxt.a = rmw_val;
            c8alu_pkg::SEL_X:  nxt.x = rmw_val;
            c8alu_pkg::SEL_Y:  nxt.y = rmw_val;
            c8alu_pkg::SEL_SP: nxt.sp = rmw_val;
            default:           writes_memory = 1'b1;
          endcase
          result_byte = rmw_val;
        end
      end
      c8alu_pkg::MODE_STA: begin
        result_byte   = cur.a;
        writes_memory = 1'b1;
      end
      c8alu_pkg::MODE_STX: begin
        result_byte   = cur.x;
        writes_memory = 1'b1;
      end
      c8alu_pkg::MODE_STY: begin
        result_byte   = cur.y;
        writes_memory = 1'b1;
      end
      c8alu_pkg::MODE_TFR: begin
        if (src_ok && tgt_ok && op.target_reg != c8alu_pkg::SEL_MEM) begin
          unique case (op.target_reg)
            c8alu_pkg::SEL_A:  nxt.a = src_val;
            c8alu_pkg::SEL_X:  nxt.x = src_val;
            c8alu_pkg::SEL_Y:  nxt.y = src_val;
            default:           nxt.sp = src_val;
          endcase
          // a move into SP leaves N and Z alone
          if (op.target_reg != c8alu_pkg::SEL_SP) begin
            nxt.p = (cur.p & c8alu_pkg::KEEP_NZ) | c8alu_pkg::nz_bits(src_val);
          end
          result_byte = src_val;
        end
      end
      c8alu_pkg::MODE_FLAG: begin
        p_tmp = cur.p;
        p_tmp[op.flag_index] = op.operand[0];
        nxt.p = p_tmp;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- design/c8alu_regs.sv -----
module c8alu_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  c8alu_pkg::regs_t nxt,
  output c8alu_pkg::regs_t cur
);

  c8alu_pkg::regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (load) begin
      regs_r <= nxt;
    end
  end

  assign cur = regs_r;

endmodule

// ----- design/cpu8_alu_register_flags_unit_top.sv -----
// 8-bit accumulator-machine ALU with its register file (A, X, Y, SP, status), binary
// arithmetic only. An operation beat is captured in an input register, executed in one
// combinational pass against the current registers, and its result beat lands in an output
// register once that register is free or draining, at which point A, X, Y, SP and status
// are updated; the register outputs always show the state after the operation on out_.
// One operation is taken every clock as long as out_ready keeps up. A, X, Y, SP and
// status clear to zero on reset.
module cpu8_alu_register_flags_unit_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] in_mode,
  input  logic [7:0] in_operand,
  input  logic [2:0] in_target_reg,
  input  logic [2:0] in_source_reg,
  input  logic [2:0] in_flag_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result_byte,
  output logic       out_writes_memory,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_x_out,
  output logic [7:0] out_y_out,
  output logic [7:0] out_sp_out,
  output logic [7:0] out_status_out
);

  logic             s1_valid_r;
  c8alu_pkg::op_t   s1_op_r;
  logic             out_valid_r;
  logic [7:0]       res_r;
  logic             wmem_r;
  logic             out_load;
  c8alu_pkg::regs_t regs_cur;
  c8alu_pkg::regs_t regs_nxt;
  logic [7:0]       exec_res;
  logic             exec_wmem;

  // advance stage 1 into the output register when that register is free or draining
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r <= '{mode: in_mode, operand: in_operand, target_reg: in_target_reg,
                   source_reg: in_source_reg, flag_index: in_flag_index};
    end
    if (out_load) begin
      res_r  <= exec_res;
      wmem_r <= exec_wmem;
    end
  end

  c8alu_exec u_exec (
    .op            (s1_op_r),
    .cur           (regs_cur),
    .nxt           (regs_nxt),
    .result_byte   (exec_res),
    .writes_memory (exec_wmem)
  );

  c8alu_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (out_load),
    .nxt   (regs_nxt),
    .cur   (regs_cur)
  );

  // registers only move with a result beat, so they match the held beat
  assign out_valid         = out_valid_r;
  assign out_result_byte   = res_r;
  assign out_writes_memory = wmem_r;
  assign out_acc_out       = regs_cur.a;
  assign out_x_out         = regs_cur.x;
  assign out_y_out         = regs_cur.y;
  assign out_sp_out        = regs_cur.sp;
  assign out_status_out    = regs_cur.p;

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(regs_cur))
    else $error("register file changed without a result beat");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_op_r))
    else $error("stalled operation lost from stage 1");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  a_wmem_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && exec_wmem |->
      (s1_op_r.mode == c8alu_pkg::MODE_STA || s1_op_r.mode == c8alu_pkg::MODE_STX ||
       s1_op_r.mode == c8alu_pkg::MODE_STY || s1_op_r.mode == c8alu_pkg::MODE_ASL ||
       s1_op_r.mode == c8alu_pkg::MODE_ROL || s1_op_r.mode == c8alu_pkg::MODE_LSR ||
       s1_op_r.mode == c8alu_pkg::MODE_ROR || s1_op_r.mode == c8alu_pkg::MODE_INC ||
       s1_op_r.mode == c8alu_pkg::MODE_DEC))
    else $error("memory write from an operation that cannot store");

  a_cmp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (s1_op_r.mode == c8alu_pkg::MODE_CMP || s1_op_r.mode == c8alu_pkg::MODE_CPX ||
                 s1_op_r.mode == c8alu_pkg::MODE_CPY || s1_op_r.mode == c8alu_pkg::MODE_BIT)
      |=> out_result_byte == 8'h00 && !out_writes_memory &&
          out_acc_out == $past(regs_cur.a) && out_x_out == $past(regs_cur.x))
    else $error("compare or bit test wrote a byte or a register");

endmodule

// ----- tb/cpu8_alu_register_flags_unit_top_test.sv -----
`timescale 1ns / 1ps

module cpu8_alu_register_flags_unit_top_test;

  localparam logic [c8alu_pkg::ModeW-1:0] MODE_SPARE = 5'd31;
  localparam logic [c8alu_pkg::SelW-1:0]  SEL_BAD    = 3'd7;
  localparam int unsigned RANDOM_OPS   = 1200;
  localparam int unsigned IDLE_PCT     = 29;
  localparam int unsigned CALM_FROM    = 500;
  localparam int unsigned CALM_TO      = 800;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0]       wbyte;
    logic             wmem;
    c8alu_pkg::regs_t regs;
  } alu_result_t;

  typedef struct {
    c8alu_pkg::op_t op;
    bit             typed;
    alu_result_t    want;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [4:0] in_mode;
  logic [7:0] in_operand;
  logic [2:0] in_target_reg;
  logic [2:0] in_source_reg;
  logic [2:0] in_flag_index;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_result_byte;
  logic       out_writes_memory;
  logic [7:0] out_acc_out;
  logic [7:0] out_x_out;
  logic [7:0] out_y_out;
  logic [7:0] out_sp_out;
  logic [7:0] out_status_out;

  c8alu_pkg::regs_t arch_regs;
  alu_result_t      awaited_results[$];
  plan_row_t        plan[$];
  bit               calm;
  bit [31:0]        modes_seen;
  int unsigned      ops_sent;
  int unsigned      results_checked;
  int unsigned      mem_writes;
  int unsigned      mismatches;
  int unsigned      stall_cycles;

  cpu8_alu_register_flags_unit_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_operand        (in_operand),
    .in_target_reg     (in_target_reg),
    .in_source_reg     (in_source_reg),
    .in_flag_index     (in_flag_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_byte   (out_result_byte),
    .out_writes_memory (out_writes_memory),
    .out_acc_out       (out_acc_out),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_sp_out        (out_sp_out),
    .out_status_out    (out_status_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [7:0] nz_flags(input logic [7:0] v);
    return {v[7], 5'b00000, (v == 8'h00), 1'b0};
  endfunction

  function automatic logic sel_ok(input logic [c8alu_pkg::SelW-1:0] sel);
    return (sel >= c8alu_pkg::SEL_A) && (sel <= c8alu_pkg::SEL_SP);
  endfunction

  function automatic logic [7:0] reg_read(input logic [c8alu_pkg::SelW-1:0] sel);
    case (sel)
      c8alu_pkg::SEL_A:  return arch_regs.a;
      c8alu_pkg::SEL_X:  return arch_regs.x;
      c8alu_pkg::SEL_Y:  return arch_regs.y;
      c8alu_pkg::SEL_SP: return arch_regs.sp;
      default:           return 8'h00;
    endcase
  endfunction

  function automatic void reg_write(input logic [c8alu_pkg::SelW-1:0] sel,
                                    input logic [7:0] v);
    case (sel)
      c8alu_pkg::SEL_A:  arch_regs.a = v;
      c8alu_pkg::SEL_X:  arch_regs.x = v;
      c8alu_pkg::SEL_Y:  arch_regs.y = v;
      c8alu_pkg::SEL_SP: arch_regs.sp = v;
      default: ;
    endcase
  endfunction

  // lhs + rhs + cin, with N V Z C worked out from the sum and the other bits kept from p_in
  function automatic logic [7:0] add8(input logic [7:0] lhs, input logic [7:0] rhs,
                                      input logic cin, input logic [7:0] p_in,
                                      output logic [7:0] p_out);
    logic [8:0] total;
    logic [7:0] r;
    total = {1'b0, lhs} + {1'b0, rhs} + {8'h00, cin};
    r = total[7:0];
    p_out = (p_in & c8alu_pkg::KEEP_NVZC) | nz_flags(r);
    p_out[c8alu_pkg::FLAG_V] = (lhs[7] ^ r[7]) & (rhs[7] ^ r[7]);
    p_out[c8alu_pkg::FLAG_C] = total[8];
    return r;
  endfunction

  function automatic alu_result_t execute_op(input c8alu_pkg::op_t op);
    alu_result_t res;
    logic [7:0]  v;
    logic [7:0]  nv;
    logic [7:0]  pv;
    res = '0;
    case (op.mode)
      c8alu_pkg::MODE_ORA, c8alu_pkg::MODE_AND, c8alu_pkg::MODE_EOR: begin
        if (op.mode == c8alu_pkg::MODE_ORA) arch_regs.a = arch_regs.a | op.operand;
        else if (op.mode == c8alu_pkg::MODE_AND) arch_regs.a = arch_regs.a & op.operand;
        else arch_regs.a = arch_regs.a ^ op.operand;
        arch_regs.p = (arch_regs.p & c8alu_pkg::KEEP_NZ) | nz_flags(arch_regs.a);
        res.wbyte = arch_regs.a;
      end
      c8alu_pkg::MODE_ADC, c8alu_pkg::MODE_SBC: begin
        v = (op.mode == c8alu_pkg::MODE_SBC) ? ~op.operand : op.operand;
        arch_regs.a = add8(arch_regs.a, v, arch_regs.p[c8alu_pkg::FLAG_C], arch_regs.p, pv);
        arch_regs.p = pv;
        res.wbyte = arch_regs.a;
      end
      c8alu_pkg::MODE_CMP, c8alu_pkg::MODE_CPX, c8alu_pkg::MODE_CPY: begin
        v = (op.mode == c8alu_pkg::MODE_CMP) ? arch_regs.a :
            (op.mode == c8alu_pkg::MODE_CPX) ? arch_regs.x : arch_regs.y;
        void'(add8(v, ~op.operand, 1'b1, arch_regs.p, pv));
        // compares leave V alone
        pv[c8alu_pkg::FLAG_V] = arch_regs.p[c8alu_pkg::FLAG_V];
        arch_regs.p = pv;
      end
      c8alu_pkg::MODE_LDA, c8alu_pkg::MODE_LDX, c8alu_pkg::MODE_LDY: begin
        if (op.mode == c8alu_pkg::MODE_LDA) arch_regs.a = op.operand;
        else if (op.mode == c8alu_pkg::MODE_LDX) arch_regs.x = op.operand;
        else arch_regs.y = op.operand;
        arch_regs.p = (arch_regs.p & c8alu_pkg::KEEP_NZ) | nz_flags(op.operand);
        res.wbyte = op.operand;
      end
      c8alu_pkg::MODE_BIT: begin
        pv = arch_regs.p & c8alu_pkg::KEEP_NVZ;
        pv[c8alu_pkg::FLAG_N] = op.operand[7];
        pv[c8alu_pkg::FLAG_V] = op.operand[6];
        pv[c8alu_pkg::FLAG_Z] = ((op.operand & arch_regs.a) == 8'h00);
        arch_regs.p = pv;
      end
      c8alu_pkg::MODE_ASL, c8alu_pkg::MODE_ROL, c8alu_pkg::MODE_LSR,
      c8alu_pkg::MODE_ROR, c8alu_pkg::MODE_INC, c8alu_pkg::MODE_DEC: begin
        if (op.target_reg == c8alu_pkg::SEL_MEM || sel_ok(op.target_reg)) begin
          v = (op.target_reg == c8alu_pkg::SEL_MEM) ? op.operand : reg_read(op.target_reg);
          case (op.mode)
            c8alu_pkg::MODE_ASL: nv = {v[6:0], 1'b0};
            c8alu_pkg::MODE_ROL: nv = {v[6:0], arch_regs.p[c8alu_pkg::FLAG_C]};
            c8alu_pkg::MODE_LSR: nv = {1'b0, v[7:1]};
            c8alu_pkg::MODE_ROR: nv = {arch_regs.p[c8alu_pkg::FLAG_C], v[7:1]};
            c8alu_pkg::MODE_INC: nv = v + 8'h01;
            default:             nv = v - 8'h01;
          endcase
          pv = (arch_regs.p & c8alu_pkg::KEEP_NZ) | nz_flags(nv);
          if (op.mode == c8alu_pkg::MODE_ASL || op.mode == c8alu_pkg::MODE_ROL) begin
            pv[c8alu_pkg::FLAG_C] = v[7];
          end else if (op.mode == c8alu_pkg::MODE_LSR || op.mode == c8alu_pkg::MODE_ROR) begin
            pv[c8alu_pkg::FLAG_C] = v[0];
          end
          arch_regs.p = pv;
          if (op.target_reg == c8alu_pkg::SEL_MEM) res.wmem = 1'b1;
          else reg_write(op.target_reg, nv);
          res.wbyte = nv;
        end
      end
      c8alu_pkg::MODE_STA, c8alu_pkg::MODE_STX, c8alu_pkg::MODE_STY: begin
        res.wbyte = (op.mode == c8alu_pkg::MODE_STA) ? arch_regs.a :
                    (op.mode == c8alu_pkg::MODE_STX) ? arch_regs.x : arch_regs.y;
        res.wmem = 1'b1;
      end
      c8alu_pkg::MODE_TFR: begin
        if (sel_ok(op.source_reg) && sel_ok(op.target_reg)) begin
          v = reg_read(op.source_reg);
          reg_write(op.target_reg, v);
          // a move into SP keeps N and Z
          if (op.target_reg != c8alu_pkg::SEL_SP) begin
            arch_regs.p = (arch_regs.p & c8alu_pkg::KEEP_NZ) | nz_flags(v);
          end
          res.wbyte = v;
        end
      end
      c8alu_pkg::MODE_FLAG: arch_regs.p[op.flag_index] = op.operand[0];
      default: ;
    endcase
    res.regs = arch_regs;
    return res;
  endfunction

  function automatic c8alu_pkg::op_t op_of(input logic [c8alu_pkg::ModeW-1:0] mode,
                                           input logic [7:0] operand,
                                           input logic [c8alu_pkg::SelW-1:0] tgt,
                                           input logic [c8alu_pkg::SelW-1:0] src,
                                           input logic [2:0] fidx);
    c8alu_pkg::op_t op;
    op.mode       = mode;
    op.operand    = operand;
    op.target_reg = tgt;
    op.source_reg = src;
    op.flag_index = fidx;
    return op;
  endfunction

  function automatic alu_result_t result_of(input logic [7:0] wbyte, input logic [7:0] a,
                                            input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] p);
    alu_result_t r;
    r.wbyte   = wbyte;
    r.wmem    = 1'b0;
    r.regs.a  = a;
    r.regs.x  = x;
    r.regs.y  = y;
    r.regs.sp = 8'h00;
    r.regs.p  = p;
    return r;
  endfunction

  function automatic logic [c8alu_pkg::SelW-1:0] random_sel(input bit mem_allowed);
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      return (pick == 0) ? c8alu_pkg::SEL_MEM : c8alu_pkg::SelW'(pick + 4);
    end
    return mem_allowed
      ? c8alu_pkg::SelW'($urandom_range(c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_SP))
      : c8alu_pkg::SelW'($urandom_range(c8alu_pkg::SEL_A, c8alu_pkg::SEL_SP));
  endfunction

  function automatic c8alu_pkg::op_t random_op();
    c8alu_pkg::op_t op;
    if ($urandom_range(0, 99) < 5) begin
      op.mode = c8alu_pkg::ModeW'($urandom_range(c8alu_pkg::MODE_FLAG + 1, MODE_SPARE));
    end else begin
      op.mode = c8alu_pkg::ModeW'($urandom_range(c8alu_pkg::MODE_ORA, c8alu_pkg::MODE_FLAG));
    end
    case ($urandom_range(0, 7))
      0:       op.operand = 8'h00;
      1:       op.operand = 8'hFF;
      2:       op.operand = 8'h80;
      3:       op.operand = 8'h7F;
      default: op.operand = 8'($urandom_range(0, 255));
    endcase
    op.target_reg = random_sel(1'b1);
    op.source_reg = random_sel(1'b0);
    op.flag_index = 3'($urandom_range(0, 7));
    return op;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the beat is taken.
  task automatic send_op(input c8alu_pkg::op_t op, input bit typed, input alu_result_t want);
    alu_result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_mode       = op.mode;
    in_operand    = op.operand;
    in_target_reg = op.target_reg;
    in_source_reg = op.source_reg;
    in_flag_index = op.flag_index;
    do @(posedge clk); while (!in_ready);
    predicted = execute_op(op);
    awaited_results.push_back(typed ? want : predicted);
    modes_seen[op.mode] = 1'b1;
    ops_sent++;
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    alu_result_t got;
    alu_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.wbyte   = out_result_byte;
      got.wmem    = out_writes_memory;
      got.regs.a  = out_acc_out;
      got.regs.x  = out_x_out;
      got.regs.y  = out_y_out;
      got.regs.sp = out_sp_out;
      got.regs.p  = out_status_out;
      if (got.wmem === 1'b1) mem_writes++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing awaited: %h", $realtime, got);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (got.wbyte !== want.wbyte || got.wmem !== want.wmem ||
            got.regs.a !== want.regs.a || got.regs.x !== want.regs.x ||
            got.regs.y !== want.regs.y || got.regs.sp !== want.regs.sp ||
            got.regs.p !== want.regs.p) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%0t: result %0d byte/wr/A/X/Y/SP/P exp %h/%b/%h/%h/%h/%h/%h",
                      " got %h/%b/%h/%h/%h/%h/%h"},
                     $realtime, results_checked,
                     want.wbyte, want.wmem, want.regs.a, want.regs.x, want.regs.y,
                     want.regs.sp, want.regs.p,
                     got.wbyte, got.wmem, got.regs.a, got.regs.x, got.regs.y,
                     got.regs.sp, got.regs.p);
        end
      end
    end
  end

  // Count cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 stall_cycles, awaited_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = c8alu_pkg::MODE_ORA;
    in_operand      = 8'h00;
    in_target_reg   = c8alu_pkg::SEL_MEM;
    in_source_reg   = c8alu_pkg::SEL_A;
    in_flag_index   = 3'd0;
    arch_regs       = '0;
    calm            = 1'b0;
    modes_seen      = '0;
    ops_sent        = 0;
    results_checked = 0;
    mem_writes      = 0;
    mismatches      = 0;
    stall_cycles    = 0;

    // loads straight out of reset, then every operation and the odd corners
    plan.push_back('{op_of(c8alu_pkg::MODE_LDA, 8'h00, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b1,
                     result_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h02)});
    plan.push_back('{op_of(c8alu_pkg::MODE_LDA, 8'hFF, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b1,
                     result_of(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80)});
    plan.push_back('{op_of(c8alu_pkg::MODE_LDX, 8'h80, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b1,
                     result_of(8'h80, 8'hFF, 8'h80, 8'h00, 8'h80)});
    plan.push_back('{op_of(c8alu_pkg::MODE_LDY, 8'h7F, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b1,
                     result_of(8'h7F, 8'hFF, 8'h80, 8'h7F, 8'h00)});
    plan.push_back('{op_of(c8alu_pkg::MODE_ADC, 8'h01, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_ADC, 8'h7F, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_SBC, 8'hFF, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_ORA, 8'h0F, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_AND, 8'hF0, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_EOR, 8'hFF, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_CMP, 8'h80, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_CPX, 8'h80, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_CPY, 8'hFF, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_BIT, 8'hC0, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_ASL, 8'h81, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_ROL, 8'h00, c8alu_pkg::SEL_A, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_LSR, 8'h00, c8alu_pkg::SEL_X, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_ROR, 8'h00, c8alu_pkg::SEL_Y, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_INC, 8'h00, c8alu_pkg::SEL_SP, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_DEC, 8'h00, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_STA, 8'h00, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_STX, 8'h00, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_STY, 8'h00, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_TFR, 8'h00, c8alu_pkg::SEL_SP, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_TFR, 8'h00, c8alu_pkg::SEL_A, c8alu_pkg::SEL_MEM,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_INC, 8'h55, SEL_BAD, c8alu_pkg::SEL_A,
                           3'd0), 1'b0, '0});
    plan.push_back('{op_of(c8alu_pkg::MODE_FLAG, 8'hFF, c8alu_pkg::SEL_MEM, c8alu_pkg::SEL_A,
                           3'd5), 1'b0, '0});
    plan.push_back('{op_of(MODE_SPARE, 8'hFF, SEL_BAD, SEL_BAD, 3'd7), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_op(plan[i].op, plan[i].typed, plan[i].want);

    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      // hold both sides busy for a stretch in the middle
      calm = (n >= CALM_FROM) && (n < CALM_TO);
      send_op(random_op(), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operations issued (%0d directed), %0d of 32 mode codes exercised",
             ops_sent, plan.size(), $countones(modes_seen));
    $display("%0d result beats checked, %0d memory writes, %0d mismatches",
             results_checked, mem_writes, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
